// ===== design/ssi_encoder_frame_checker_defines.svh =====
// ----------------------------------------------------------------------------
// SSI encoder frame checker assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SSI_ENCODER_FRAME_CHECKER_DEFINES_SVH
`define SSI_ENCODER_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication
`define SSIEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssiec implication check failed");

// next-cycle implication
`define SSIEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssiec next-cycle check failed");

`endif

// ===== design/ssiec_pkg.sv =====
// ----------------------------------------------------------------------------
// SSI encoder frame checker package
// Opcodes, error codes, register map and shared structs.
// ----------------------------------------------------------------------------
package ssiec_pkg;

   localparam int OPCODE_W   = 2;
   localparam int FRAME_W    = 32;
   localparam int ANGLE_W    = 12;
   localparam int ERROR_W    = 3;
   localparam int LIMIT_W    = 4;
   localparam int COUNT_W    = LIMIT_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OPCODE_W-1:0] OP_FRAME     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BUS_ERROR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RESTART   = 2'd2;

   localparam logic [ERROR_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [ERROR_W-1:0] ERR_NO_RESPONSE = 3'd1;
   localparam logic [ERROR_W-1:0] ERR_PARITY      = 3'd2;
   localparam logic [ERROR_W-1:0] ERR_OCF         = 3'd3;
   localparam logic [ERROR_W-1:0] ERR_COF         = 3'd4;

   localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 4'd3;

   // word index of each register (byte address bit 2 and up)
   localparam logic RETRY_LIMIT_IDX = 1'b0;

   typedef struct packed {
      logic                 is_restart;
      logic                 is_fail;
      logic                 is_good;
      logic [ERROR_W-1:0]   fail_code;
      logic                 parsed;
      logic [ANGLE_W-1:0]   angle;
      logic                 lin;
      logic                 mag_inc;
      logic                 mag_dec;
   } parse_type;

   typedef struct packed {
      logic                 retry;
      logic                 report;
      logic                 set_global;
      logic [ERROR_W-1:0]   fault_code;
   } track_type;

endpackage

// ===== design/ssiec_csr.sv =====
// ----------------------------------------------------------------------------
// SSI encoder frame checker register port
// APB-style access to the retry limit register.
// ----------------------------------------------------------------------------
module ssiec_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssiec_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ssiec_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ssiec_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output logic [ssiec_pkg::LIMIT_W-1:0]      retry_limit
);
   import ssiec_pkg::*;

   logic [LIMIT_W-1:0] retry_limit_ff;
   logic [LIMIT_W-1:0] retry_limit_in;
   logic               wr_hit;
   logic               rd_hit;

   assign csr_pready = 1'b1;
   assign rd_hit     = (csr_paddr[CSR_ADDR_W-1] == RETRY_LIMIT_IDX);
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & rd_hit;

   always_comb begin
      retry_limit_in = retry_limit_ff;
      if (wr_hit) begin
         retry_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else begin
         retry_limit_ff <= retry_limit_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (rd_hit) begin
         csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, retry_limit_ff};
      end
   end

   assign retry_limit = retry_limit_ff;

endmodule

// ===== design/ssiec_frame_parse.sv =====
// ----------------------------------------------------------------------------
// SSI encoder frame parser
// Classifies one item and pulls angle, flags and parity out of the frame.
// ----------------------------------------------------------------------------
module ssiec_frame_parse (
   input  logic [ssiec_pkg::OPCODE_W-1:0]  opcode,
   input  logic [ssiec_pkg::FRAME_W-1:0]   frame_word,
   output ssiec_pkg::parse_type            parse
);
   import ssiec_pkg::*;

   logic [17:0] raw;
   logic        no_resp;
   logic        par_ok;

   assign raw     = {frame_word[30:24], frame_word[23:16], frame_word[15:13]};
   assign no_resp = (frame_word == '0) || (frame_word == '1);
   assign par_ok  = ((^raw[17:1]) == raw[0]);

   always_comb begin
      parse            = '0;
      parse.fail_code  = ERR_NO_RESPONSE;
      unique case (opcode)
         OP_RESTART: begin
            parse.is_restart = 1'b1;
         end
         OP_BUS_ERROR: begin
            parse.is_fail = 1'b1;
         end
         OP_FRAME: begin
            if (no_resp) begin
               parse.is_fail = 1'b1;
            end else begin
               parse.parsed  = 1'b1;
               parse.angle   = raw[17:6];
               parse.lin     = raw[3];
               parse.mag_inc = raw[2];
               parse.mag_dec = raw[1];
               priority if (!par_ok) begin
                  parse.is_fail   = 1'b1;
                  parse.fail_code = ERR_PARITY;
               end else if (!raw[5]) begin
                  parse.is_fail   = 1'b1;
                  parse.fail_code = ERR_OCF;
               end else if (raw[4]) begin
                  parse.is_fail   = 1'b1;
                  parse.fail_code = ERR_COF;
               end else begin
                  parse.is_good = 1'b1;
               end
            end
         end
         default: begin
            parse.fail_code = ERR_NONE;
         end
      endcase
   end

endmodule

// ===== design/ssiec_fail_track.sv =====
// ----------------------------------------------------------------------------
// SSI encoder failure tracker
// Saturating fail counter, persistent-report latch and last error code.
// ----------------------------------------------------------------------------
module ssiec_fail_track (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [ssiec_pkg::LIMIT_W-1:0]   retry_limit,
   input  logic                            motor_is_source,
   input  ssiec_pkg::parse_type            parse,
   output ssiec_pkg::track_type            track
);
   import ssiec_pkg::*;

   logic [COUNT_W-1:0] fail_count_ff;
   logic [COUNT_W-1:0] fail_count_in;
   logic               latched_ff;
   logic               latched_in;
   logic [ERROR_W-1:0] last_error_ff;
   logic [ERROR_W-1:0] last_error_in;
   logic [COUNT_W-1:0] lim_ext;
   logic [COUNT_W-1:0] fail_bump;

   assign lim_ext   = {1'b0, retry_limit};
   assign fail_bump = (fail_count_ff > lim_ext) ? lim_ext + 1'b1 : fail_count_ff + 1'b1;

   always_comb begin
      fail_count_in    = fail_count_ff;
      latched_in       = latched_ff;
      last_error_in    = last_error_ff;
      track            = '0;
      priority if (parse.is_restart) begin
         fail_count_in = '0;
         latched_in    = 1'b0;
      end else if (parse.is_fail) begin
         fail_count_in    = fail_bump;
         last_error_in    = parse.fail_code;
         track.set_global = !motor_is_source;
         if (fail_bump <= lim_ext) begin
            track.retry = 1'b1;
         end else if (!latched_ff) begin
            latched_in   = 1'b1;
            track.report = !motor_is_source;
         end
      end else if (parse.is_good) begin
         fail_count_in = '0;
         latched_in    = 1'b0;
         last_error_in = ERR_NONE;
      end
      track.fault_code = last_error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_count_ff <= '0;
         latched_ff    <= 1'b0;
         last_error_ff <= ERR_NONE;
      end else if (advance) begin
         fail_count_ff <= fail_count_in;
         latched_ff    <= latched_in;
         last_error_ff <= last_error_in;
      end
   end

endmodule

// ===== design/ssi_encoder_frame_checker.sv =====
// ----------------------------------------------------------------------------
// SSI encoder frame checker
// Checks SSI frames, bus errors and restarts; one result per transfer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | opcode, frame_word, motor_is_source
//   rsp     | out       | rsp_valid/rsp_stall  | angle, flags, fault_code
//   csr     | in/out    | APB psel/penable     | retry_limit at byte address 0
//
// A transfer passes the input register, then the result register.
// One transfer per cycle unless the result is stalled; the parse and counter update sit between the two.
// Synchronous reset clears valids, counter, latch and last error, and sets the limit to 3.
// A stalled result holds; the input register still takes one more transfer.
// ----------------------------------------------------------------------------
module ssi_encoder_frame_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ssiec_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [ssiec_pkg::FRAME_W-1:0]      req_frame_word,
   input  logic                               req_motor_is_source,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ssiec_pkg::ANGLE_W-1:0]      rsp_angle,
   output logic                               rsp_angle_valid,
   output logic [ssiec_pkg::ERROR_W-1:0]      rsp_fault_code,
   output logic                               rsp_retry_request,
   output logic                               rsp_report_persistent,
   output logic                               rsp_set_global_error,
   output logic                               rsp_clear_encoder_error,
   output logic                               rsp_linearity_warning,
   output logic                               rsp_magnet_increase,
   output logic                               rsp_magnet_decrease,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssiec_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ssiec_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ssiec_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import ssiec_pkg::*;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [OPCODE_W-1:0] in_opcode_ff;
   logic [FRAME_W-1:0]  in_frame_ff;
   logic                in_msrc_ff;
   logic                req_take;
   logic                advance;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [LIMIT_W-1:0]  retry_limit;
   parse_type           parse;
   track_type           track;

   logic [ANGLE_W-1:0]  angle_ff;
   logic                angle_valid_ff;
   logic [ERROR_W-1:0]  fault_code_ff;
   logic                retry_ff;
   logic                report_ff;
   logic                set_global_ff;
   logic                clear_err_ff;
   logic                lin_ff;
   logic                mag_inc_ff;
   logic                mag_dec_ff;

   ssiec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .retry_limit (retry_limit)
   );

   ssiec_frame_parse u_parse (
      .opcode     (in_opcode_ff),
      .frame_word (in_frame_ff),
      .parse      (parse)
   );

   ssiec_fail_track u_track (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .retry_limit     (retry_limit),
      .motor_is_source (in_msrc_ff),
      .parse           (parse),
      .track           (track)
   );

   assign advance      = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall    = in_valid_ff & ~advance;
   assign req_take     = req_valid & ~req_stall;
   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_opcode;
         in_frame_ff  <= req_frame_word;
         in_msrc_ff   <= req_motor_is_source;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff       <= parse.is_good ? parse.angle : '0;
         angle_valid_ff <= parse.is_good;
         fault_code_ff  <= track.fault_code;
         retry_ff       <= track.retry;
         report_ff      <= track.report;
         set_global_ff  <= track.set_global;
         clear_err_ff   <= parse.is_good;
         lin_ff         <= parse.parsed & parse.lin;
         mag_inc_ff     <= parse.parsed & parse.mag_inc;
         mag_dec_ff     <= parse.parsed & parse.mag_dec;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_angle               = angle_ff;
   assign rsp_angle_valid         = angle_valid_ff;
   assign rsp_fault_code          = fault_code_ff;
   assign rsp_retry_request       = retry_ff;
   assign rsp_report_persistent   = report_ff;
   assign rsp_set_global_error    = set_global_ff;
   assign rsp_clear_encoder_error = clear_err_ff;
   assign rsp_linearity_warning   = lin_ff;
   assign rsp_magnet_increase     = mag_inc_ff;
   assign rsp_magnet_decrease     = mag_dec_ff;

endmodule

// ===== design/ssiec_checker.sv =====
// ----------------------------------------------------------------------------
// SSI encoder frame checker port assertions
// Result consistency and output hold checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "ssi_encoder_frame_checker_defines.svh"

module ssiec_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [ssiec_pkg::ANGLE_W-1:0]    rsp_angle,
   input logic                             rsp_angle_valid,
   input logic [ssiec_pkg::ERROR_W-1:0]    rsp_fault_code,
   input logic                             rsp_retry_request,
   input logic                             rsp_report_persistent,
   input logic                             rsp_set_global_error,
   input logic                             rsp_clear_encoder_error
);
   import ssiec_pkg::*;

   `SSIEC_ASSERT_IMPLY(a_good_no_error, clock, reset, rsp_valid && rsp_angle_valid,
      rsp_fault_code == ERR_NONE && rsp_clear_encoder_error && !rsp_set_global_error)
   `SSIEC_ASSERT_IMPLY(a_retry_or_report, clock, reset, rsp_valid,
      !(rsp_retry_request && rsp_report_persistent))
   `SSIEC_ASSERT_IMPLY(a_bad_zero_angle, clock, reset, rsp_valid && !rsp_angle_valid,
      rsp_angle == '0 && !rsp_clear_encoder_error)
   `SSIEC_ASSERT_IMPLY(a_report_has_error, clock, reset, rsp_valid && rsp_report_persistent,
      rsp_set_global_error && rsp_fault_code != ERR_NONE)
   `SSIEC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_angle) && $stable(rsp_fault_code))

endmodule

bind ssi_encoder_frame_checker ssiec_checker u_ssiec_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_angle               (rsp_angle),
   .rsp_angle_valid         (rsp_angle_valid),
   .rsp_fault_code          (rsp_fault_code),
   .rsp_retry_request       (rsp_retry_request),
   .rsp_report_persistent   (rsp_report_persistent),
   .rsp_set_global_error    (rsp_set_global_error),
   .rsp_clear_encoder_error (rsp_clear_encoder_error)
);
